@@ hdl/sit_pkg.sv @@
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types and constants for the segment intersection test pipeline.
// ----------------------------------------------------------------------------
package sit_pkg;

   typedef logic [1:0] case_type;

   localparam case_type CASE_GENERAL   = 2'd0;
   localparam case_type CASE_P_VERT    = 2'd1;
   localparam case_type CASE_Q_VERT    = 2'd2;
   localparam case_type CASE_BOTH_VERT = 2'd3;

   localparam int TOL_WIDTH = 8;
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 8'd26;

endpackage

@@ hdl/sit_front.sv @@
// ----------------------------------------------------------------------------
// sit_front
// Three stages: differences and boxes, products, determinant and numerators.
// ----------------------------------------------------------------------------
module sit_front #(
   parameter int W = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic signed [W-1:0]             p1_x,
   input  logic signed [W-1:0]             p1_y,
   input  logic signed [W-1:0]             p2_x,
   input  logic signed [W-1:0]             p2_y,
   input  logic signed [W-1:0]             q1_x,
   input  logic signed [W-1:0]             q1_y,
   input  logic signed [W-1:0]             q2_x,
   input  logic signed [W-1:0]             q2_y,
   input  logic [sit_pkg::TOL_WIDTH-1:0]   tol,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic signed [2*W+1:0]           den,
   output logic signed [2*W+1:0]           cr,
   output logic signed [2*W+1:0]           nvq,
   output logic signed [2*W+1:0]           nvp,
   output logic signed [W-1:0]             p1x_o,
   output logic signed [W-1:0]             p1y_o,
   output logic signed [W-1:0]             q1x_o,
   output logic signed [W:0]               dxp_o,
   output logic signed [W:0]               dyp_o,
   output logic signed [W:0]               dxq_o,
   output sit_pkg::case_type               case_o,
   output logic [4*(W+1)-1:0]              bounds
);

   localparam int DW = 2*W+2;

   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;

   // stage 1
   logic signed [W:0]   dxp_in, dyp_in, dxq_in, dyq_in, ex_in, ey_in;
   logic signed [W:0]   dxp1_ff, dyp1_ff, dxq1_ff, dyq1_ff, ex1_ff, ey1_ff;
   logic signed [W-1:0] p1x1_ff, p1y1_ff, q1x1_ff, q1y1_ff;
   sit_pkg::case_type   case_in, case1_ff;
   logic signed [W-1:0] pxmin_in, pxmax_in, pymin_in, pymax_in;
   logic signed [W-1:0] qxmin_in, qxmax_in, qymin_in, qymax_in;
   logic signed [W-1:0] pxmin_ff, pxmax_ff, pymin_ff, pymax_ff;
   logic signed [W-1:0] qxmin_ff, qxmax_ff, qymin_ff, qymax_ff;

   // stage 2
   logic signed [DW-1:0] ma_in, mb_in, mc_in, md_in, me_in, mf_in, mg_in;
   logic signed [DW-1:0] ma_ff, mb_ff, mc_ff, md_ff, me_ff, mf_ff, mg_ff;
   logic signed [W-1:0]  lo_x, hi_x, lo_y, hi_y;
   logic [W:0]           xlo_in, xhi_in, ylo_in, yhi_in;
   logic [W:0]           xlo2_ff, xhi2_ff, ylo2_ff, yhi2_ff;
   logic signed [W-1:0]  p1x2_ff, p1y2_ff, q1x2_ff;
   logic signed [W:0]    dxp2_ff, dyp2_ff, dxq2_ff;
   sit_pkg::case_type    case2_ff;

   // stage 3
   logic signed [DW-1:0] den_ff, cr_ff, nvq_ff, nvp_ff;
   logic [W:0]           xlo3_ff, xhi3_ff, ylo3_ff, yhi3_ff;
   logic signed [W-1:0]  p1x3_ff, p1y3_ff, q1x3_ff;
   logic signed [W:0]    dxp3_ff, dyp3_ff, dxq3_ff;
   sit_pkg::case_type    case3_ff;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      dxp_in = {p2_x[W-1], p2_x} - {p1_x[W-1], p1_x};
      dyp_in = {p2_y[W-1], p2_y} - {p1_y[W-1], p1_y};
      dxq_in = {q2_x[W-1], q2_x} - {q1_x[W-1], q1_x};
      dyq_in = {q2_y[W-1], q2_y} - {q1_y[W-1], q1_y};
      ex_in  = {q1_x[W-1], q1_x} - {p1_x[W-1], p1_x};
      ey_in  = {q1_y[W-1], q1_y} - {p1_y[W-1], p1_y};
      if (dxp_in == '0 && dxq_in == '0) begin
         case_in = sit_pkg::CASE_BOTH_VERT;
      end else if (dxp_in == '0) begin
         case_in = sit_pkg::CASE_P_VERT;
      end else if (dxq_in == '0) begin
         case_in = sit_pkg::CASE_Q_VERT;
      end else begin
         case_in = sit_pkg::CASE_GENERAL;
      end
      pxmin_in = (p1_x < p2_x) ? p1_x : p2_x;
      pxmax_in = (p1_x < p2_x) ? p2_x : p1_x;
      pymin_in = (p1_y < p2_y) ? p1_y : p2_y;
      pymax_in = (p1_y < p2_y) ? p2_y : p1_y;
      qxmin_in = (q1_x < q2_x) ? q1_x : q2_x;
      qxmax_in = (q1_x < q2_x) ? q2_x : q1_x;
      qymin_in = (q1_y < q2_y) ? q1_y : q2_y;
      qymax_in = (q1_y < q2_y) ? q2_y : q1_y;
   end

   always_comb begin
      ma_in = dxp1_ff * dyq1_ff;
      mb_in = dyp1_ff * dxq1_ff;
      mc_in = ex1_ff * dyq1_ff;
      md_in = ey1_ff * dxq1_ff;
      me_in = q1y1_ff * dxq1_ff;
      mf_in = p1y1_ff * dxp1_ff;
      mg_in = ex1_ff * dyp1_ff;
      lo_x  = (pxmin_ff > qxmin_ff) ? pxmin_ff : qxmin_ff;
      hi_x  = (pxmax_ff < qxmax_ff) ? pxmax_ff : qxmax_ff;
      lo_y  = (pymin_ff > qymin_ff) ? pymin_ff : qymin_ff;
      hi_y  = (pymax_ff < qymax_ff) ? pymax_ff : qymax_ff;
      xlo_in = {lo_x[W-1], lo_x} - {{(W-7){1'b0}}, tol};
      xhi_in = {hi_x[W-1], hi_x} + {{(W-7){1'b0}}, tol};
      ylo_in = {lo_y[W-1], lo_y} - {{(W-7){1'b0}}, tol};
      yhi_in = {hi_y[W-1], hi_y} + {{(W-7){1'b0}}, tol};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         dxp1_ff  <= dxp_in;
         dyp1_ff  <= dyp_in;
         dxq1_ff  <= dxq_in;
         dyq1_ff  <= dyq_in;
         ex1_ff   <= ex_in;
         ey1_ff   <= ey_in;
         p1x1_ff  <= p1_x;
         p1y1_ff  <= p1_y;
         q1x1_ff  <= q1_x;
         q1y1_ff  <= q1_y;
         case1_ff <= case_in;
         pxmin_ff <= pxmin_in;
         pxmax_ff <= pxmax_in;
         pymin_ff <= pymin_in;
         pymax_ff <= pymax_in;
         qxmin_ff <= qxmin_in;
         qxmax_ff <= qxmax_in;
         qymin_ff <= qymin_in;
         qymax_ff <= qymax_in;
      end
      if (rdy2) begin
         ma_ff    <= ma_in;
         mb_ff    <= mb_in;
         mc_ff    <= mc_in;
         md_ff    <= md_in;
         me_ff    <= me_in;
         mf_ff    <= mf_in;
         mg_ff    <= mg_in;
         xlo2_ff  <= xlo_in;
         xhi2_ff  <= xhi_in;
         ylo2_ff  <= ylo_in;
         yhi2_ff  <= yhi_in;
         p1x2_ff  <= p1x1_ff;
         p1y2_ff  <= p1y1_ff;
         q1x2_ff  <= q1x1_ff;
         dxp2_ff  <= dxp1_ff;
         dyp2_ff  <= dyp1_ff;
         dxq2_ff  <= dxq1_ff;
         case2_ff <= case1_ff;
      end
      if (rdy3) begin
         den_ff   <= ma_ff - mb_ff;
         cr_ff    <= mc_ff - md_ff;
         nvq_ff   <= me_ff - mc_ff;
         nvp_ff   <= mf_ff + mg_ff;
         xlo3_ff  <= xlo2_ff;
         xhi3_ff  <= xhi2_ff;
         ylo3_ff  <= ylo2_ff;
         yhi3_ff  <= yhi2_ff;
         p1x3_ff  <= p1x2_ff;
         p1y3_ff  <= p1y2_ff;
         q1x3_ff  <= q1x2_ff;
         dxp3_ff  <= dxp2_ff;
         dyp3_ff  <= dyp2_ff;
         dxq3_ff  <= dxq2_ff;
         case3_ff <= case2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign den       = den_ff;
   assign cr        = cr_ff;
   assign nvq       = nvq_ff;
   assign nvp       = nvp_ff;
   assign p1x_o     = p1x3_ff;
   assign p1y_o     = p1y3_ff;
   assign q1x_o     = q1x3_ff;
   assign dxp_o     = dxp3_ff;
   assign dyp_o     = dyp3_ff;
   assign dxq_o     = dxq3_ff;
   assign case_o    = case3_ff;
   assign bounds    = {xlo3_ff, xhi3_ff, ylo3_ff, yhi3_ff};

endmodule

@@ hdl/sit_scale.sv @@
// ----------------------------------------------------------------------------
// sit_scale
// Four stages: split products, product merge, case select, magnitudes.
// ----------------------------------------------------------------------------
module sit_scale #(
   parameter int W = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [2*W+1:0]     den,
   input  logic signed [2*W+1:0]     cr,
   input  logic signed [2*W+1:0]     nvq,
   input  logic signed [2*W+1:0]     nvp,
   input  logic signed [W-1:0]       p1x,
   input  logic signed [W-1:0]       p1y,
   input  logic signed [W-1:0]       q1x,
   input  logic signed [W:0]         dxp,
   input  logic signed [W:0]         dyp,
   input  logic signed [W:0]         dxq,
   input  sit_pkg::case_type         case_i,
   input  logic [4*(W+1)-1:0]        bounds,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [1:0][3*W+2:0]       nm,
   output logic [1:0][2*W+1:0]       dm,
   output logic [1:0]                neg,
   output logic [4*(W+1):0]          side
);

   localparam int DW = 2*W+2;
   localparam int NW = 3*W+3;
   localparam int K  = W+1;
   localparam int PW = 2*W+3;
   localparam int BW = 4*(W+1);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   logic signed [W:0]    denh, crh;
   logic signed [K:0]    denl, crl;

   // stage 1
   logic signed [PW-1:0] ah_ff, al_ff, bh_ff, bl_ff, ch_ff, cl_ff, dh_ff, dl_ff;
   logic                 par1_ff;
   logic signed [DW-1:0] den1_ff, nvq1_ff, nvp1_ff;
   logic signed [W-1:0]  p1x1_ff, q1x1_ff;
   logic signed [W:0]    dxp1_ff, dxq1_ff;
   sit_pkg::case_type    case1_ff;
   logic [BW-1:0]        bnd1_ff;

   // stage 2
   logic signed [NW-1:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic                 par2_ff;
   logic signed [DW-1:0] den2_ff, nvq2_ff, nvp2_ff;
   logic signed [W-1:0]  p1x2_ff, q1x2_ff;
   logic signed [W:0]    dxp2_ff, dxq2_ff;
   sit_pkg::case_type    case2_ff;
   logic [BW-1:0]        bnd2_ff;

   // stage 3
   logic signed [NW-1:0] xn_in, yn_in, xn_ff, yn_ff;
   logic signed [DW-1:0] xd_in, yd_in, xd_ff, yd_ff;
   logic                 ok3_ff;
   logic [BW-1:0]        bnd3_ff;

   // stage 4
   logic [1:0][NW-1:0]   nm_ff;
   logic [1:0][DW-1:0]   dm_ff;
   logic [1:0]           neg_ff;
   logic [BW:0]          side_ff;

   assign rdy4     = !v4_ff || out_ready;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   assign denh = den[DW-1:K];
   assign denl = {1'b0, den[K-1:0]};
   assign crh  = cr[DW-1:K];
   assign crl  = {1'b0, cr[K-1:0]};

   always_comb begin
      case (case2_ff)
         sit_pkg::CASE_GENERAL: begin
            xn_in = pa_ff + pb_ff;
            yn_in = pc_ff + pd_ff;
            xd_in = den2_ff;
            yd_in = den2_ff;
         end
         sit_pkg::CASE_P_VERT: begin
            xn_in = NW'(p1x2_ff);
            yn_in = NW'(nvq2_ff);
            xd_in = DW'(1);
            yd_in = DW'(dxq2_ff);
         end
         sit_pkg::CASE_Q_VERT: begin
            xn_in = NW'(q1x2_ff);
            yn_in = NW'(nvp2_ff);
            xd_in = DW'(1);
            yd_in = DW'(dxp2_ff);
         end
         default: begin
            xn_in = '0;
            yn_in = '0;
            xd_in = DW'(1);
            yd_in = DW'(1);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         ah_ff    <= p1x * denh;
         al_ff    <= p1x * denl;
         bh_ff    <= dxp * crh;
         bl_ff    <= dxp * crl;
         ch_ff    <= p1y * denh;
         cl_ff    <= p1y * denl;
         dh_ff    <= dyp * crh;
         dl_ff    <= dyp * crl;
         par1_ff  <= (case_i == sit_pkg::CASE_GENERAL) && (den == '0);
         den1_ff  <= den;
         nvq1_ff  <= nvq;
         nvp1_ff  <= nvp;
         p1x1_ff  <= p1x;
         q1x1_ff  <= q1x;
         dxp1_ff  <= dxp;
         dxq1_ff  <= dxq;
         case1_ff <= case_i;
         bnd1_ff  <= bounds;
      end
      if (rdy2) begin
         pa_ff    <= (NW'(ah_ff) <<< K) + NW'(al_ff);
         pb_ff    <= (NW'(bh_ff) <<< K) + NW'(bl_ff);
         pc_ff    <= (NW'(ch_ff) <<< K) + NW'(cl_ff);
         pd_ff    <= (NW'(dh_ff) <<< K) + NW'(dl_ff);
         par2_ff  <= par1_ff;
         den2_ff  <= den1_ff;
         nvq2_ff  <= nvq1_ff;
         nvp2_ff  <= nvp1_ff;
         p1x2_ff  <= p1x1_ff;
         q1x2_ff  <= q1x1_ff;
         dxp2_ff  <= dxp1_ff;
         dxq2_ff  <= dxq1_ff;
         case2_ff <= case1_ff;
         bnd2_ff  <= bnd1_ff;
      end
      if (rdy3) begin
         xn_ff   <= xn_in;
         yn_ff   <= yn_in;
         xd_ff   <= xd_in;
         yd_ff   <= yd_in;
         ok3_ff  <= !par2_ff;
         bnd3_ff <= bnd2_ff;
      end
      if (rdy4) begin
         nm_ff[0]  <= xn_ff[NW-1] ? NW'(-xn_ff) : NW'(xn_ff);
         nm_ff[1]  <= yn_ff[NW-1] ? NW'(-yn_ff) : NW'(yn_ff);
         dm_ff[0]  <= xd_ff[DW-1] ? DW'(-xd_ff) : DW'(xd_ff);
         dm_ff[1]  <= yd_ff[DW-1] ? DW'(-yd_ff) : DW'(yd_ff);
         neg_ff[0] <= xn_ff[NW-1] ^ xd_ff[DW-1];
         neg_ff[1] <= yn_ff[NW-1] ^ yd_ff[DW-1];
         side_ff   <= {ok3_ff, bnd3_ff};
      end
   end

   assign out_valid = v4_ff;
   assign nm        = nm_ff;
   assign dm        = dm_ff;
   assign neg       = neg_ff;
   assign side      = side_ff;

endmodule

@@ hdl/sit_div.sv @@
// ----------------------------------------------------------------------------
// sit_div
// Pipelined restoring divider, two lanes, one quotient bit per stage after the input stage.
// ----------------------------------------------------------------------------
module sit_div #(
   parameter int W = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [1:0][3*W+2:0]    nm,
   input  logic [1:0][2*W+1:0]    dm,
   input  logic [1:0]             neg,
   input  logic [4*(W+1):0]       side,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [1:0][W:0]        q,
   output logic [1:0]             neg_o,
   output logic [1:0]             ovf,
   output logic [4*(W+1):0]       side_o
);

   localparam int DW = 2*W+2;
   localparam int NW = 3*W+3;
   localparam int QB = W+1;
   localparam int NS = QB+1;
   localparam int SW = 4*(W+1)+1;

   logic [NS-1:0]      v_ff;
   logic [NS:0]        rdy;
   logic [1:0][NW-1:0] r_ff   [NS];
   logic [1:0][NW-1:0] r_in   [NS];
   logic [1:0][DW-1:0] d_ff   [NS];
   logic [1:0][QB-1:0] q_ff   [NS];
   logic [1:0][QB-1:0] q_in   [NS];
   logic [1:0]         neg_ff [NS];
   logic [1:0]         ovf_ff [NS];
   logic [1:0]         ovf_in [NS];
   logic [SW-1:0]      side_ff[NS];

   always_comb begin
      rdy[NS] = out_ready;
      for (int s = NS-1; s >= 0; s--) begin
         rdy[s] = !v_ff[s] || rdy[s+1];
      end
   end

   assign in_ready = rdy[0];

   always_comb begin
      logic [NW-1:0] sh;
      logic [NW:0]   diff;
      sh   = '0;
      diff = '0;
      for (int l = 0; l < 2; l++) begin
         ovf_in[0][l] = nm[l] >= {dm[l], {QB{1'b0}}};
         r_in[0][l]   = nm[l];
         q_in[0][l]   = '0;
         for (int s = 1; s < NS; s++) begin
            sh           = NW'(d_ff[s-1][l]) << (QB - s);
            diff         = {1'b0, r_ff[s-1][l]} - {1'b0, sh};
            r_in[s][l]   = diff[NW] ? r_ff[s-1][l] : diff[NW-1:0];
            q_in[s][l]   = {q_ff[s-1][l][QB-2:0], !diff[NW]};
            ovf_in[s][l] = ovf_ff[s-1][l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) v_ff[0] <= in_valid;
         for (int s = 1; s < NS; s++) begin
            if (rdy[s]) v_ff[s] <= v_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         r_ff[0]    <= r_in[0];
         q_ff[0]    <= q_in[0];
         ovf_ff[0]  <= ovf_in[0];
         d_ff[0]    <= dm;
         neg_ff[0]  <= neg;
         side_ff[0] <= side;
      end
      for (int s = 1; s < NS; s++) begin
         if (rdy[s]) begin
            r_ff[s]    <= r_in[s];
            q_ff[s]    <= q_in[s];
            ovf_ff[s]  <= ovf_in[s];
            d_ff[s]    <= d_ff[s-1];
            neg_ff[s]  <= neg_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign q         = q_ff[NS-1];
   assign neg_o     = neg_ff[NS-1];
   assign ovf       = ovf_ff[NS-1];
   assign side_o    = side_ff[NS-1];

endmodule

@@ hdl/sit_back.sv @@
// ----------------------------------------------------------------------------
// sit_back
// Signs the quotients, runs the box test and holds the result beat.
// ----------------------------------------------------------------------------
module sit_back #(
   parameter int W = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [1:0][W:0]      q,
   input  logic [1:0]           neg,
   input  logic [1:0]           ovf,
   input  logic [4*(W+1):0]     side,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic                 hit,
   output logic signed [W-1:0]  cross_x,
   output logic signed [W-1:0]  cross_y
);

   localparam int BW = 4*(W+1);

   logic v1_ff, v2_ff;
   logic rdy1, rdy2;

   logic signed [W+1:0] xs_ff, ys_ff;
   logic [1:0]          ovf1_ff;
   logic [BW:0]         side1_ff;

   logic                ok;
   logic signed [W:0]   xlo, xhi, ylo, yhi;
   logic                hit_in;
   logic signed [W+1:0] max_v, min_v;
   logic signed [W-1:0] cx_in, cy_in;

   logic                hit_ff;
   logic signed [W-1:0] cx_ff, cy_ff;

   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   assign ok    = side1_ff[BW];
   assign xlo   = side1_ff[4*(W+1)-1 -: W+1];
   assign xhi   = side1_ff[3*(W+1)-1 -: W+1];
   assign ylo   = side1_ff[2*(W+1)-1 -: W+1];
   assign yhi   = side1_ff[W:0];
   assign max_v = {3'b000, {(W-1){1'b1}}};
   assign min_v = {3'b111, {(W-1){1'b0}}};

   always_comb begin
      hit_in = ok && !ovf1_ff[0] && !ovf1_ff[1]
               && xs_ff >= xlo && xs_ff <= xhi && ys_ff >= ylo && ys_ff <= yhi;
      if (xs_ff > max_v) begin
         cx_in = max_v[W-1:0];
      end else if (xs_ff < min_v) begin
         cx_in = min_v[W-1:0];
      end else begin
         cx_in = xs_ff[W-1:0];
      end
      if (ys_ff > max_v) begin
         cy_in = max_v[W-1:0];
      end else if (ys_ff < min_v) begin
         cy_in = min_v[W-1:0];
      end else begin
         cy_in = ys_ff[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         xs_ff    <= neg[0] ? -$signed({1'b0, q[0]}) : $signed({1'b0, q[0]});
         ys_ff    <= neg[1] ? -$signed({1'b0, q[1]}) : $signed({1'b0, q[1]});
         ovf1_ff  <= ovf;
         side1_ff <= side;
      end
      if (rdy2) begin
         hit_ff <= hit_in;
         cx_ff  <= hit_in ? cx_in : '0;
         cy_ff  <= hit_in ? cy_in : '0;
      end
   end

   assign out_valid = v2_ff;
   assign hit       = hit_ff;
   assign cross_x   = cx_ff;
   assign cross_y   = cy_ff;

endmodule

@@ hdl/segment_intersection_test_top.sv @@
// ----------------------------------------------------------------------------
// segment_intersection_test_top
// Intersection point of two segments with a widened bounding box hit test.
// Throughput: one pair per cycle unless rsp_ready holds the pipeline back;
// the divider takes one quotient bit per stage after its input stage.
// Reset: synchronous, clears all stage valid bits, tolerance returns to 26.
// ----------------------------------------------------------------------------
module segment_intersection_test_top #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [COORD_WIDTH-1:0]  req_p1_x,
   input  logic signed [COORD_WIDTH-1:0]  req_p1_y,
   input  logic signed [COORD_WIDTH-1:0]  req_p2_x,
   input  logic signed [COORD_WIDTH-1:0]  req_p2_y,
   input  logic signed [COORD_WIDTH-1:0]  req_q1_x,
   input  logic signed [COORD_WIDTH-1:0]  req_q1_y,
   input  logic signed [COORD_WIDTH-1:0]  req_q2_x,
   input  logic signed [COORD_WIDTH-1:0]  req_q2_y,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_hit,
   output logic signed [COORD_WIDTH-1:0]  rsp_cross_x,
   output logic signed [COORD_WIDTH-1:0]  rsp_cross_y,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sit_pkg::TOL_WIDTH-1:0]  csr_data
);

   localparam int W  = COORD_WIDTH;
   localparam int DW = 2*W+2;
   localparam int NW = 3*W+3;
   localparam int SW = 4*(W+1)+1;

   logic [sit_pkg::TOL_WIDTH-1:0] tol_ff;

   logic                 f_valid, f_ready;
   logic signed [DW-1:0] f_den, f_cr, f_nvq, f_nvp;
   logic signed [W-1:0]  f_p1x, f_p1y, f_q1x;
   logic signed [W:0]    f_dxp, f_dyp, f_dxq;
   sit_pkg::case_type    f_case;
   logic [4*(W+1)-1:0]   f_bounds;

   logic                 s_valid, s_ready;
   logic [1:0][NW-1:0]   s_nm;
   logic [1:0][DW-1:0]   s_dm;
   logic [1:0]           s_neg;
   logic [SW-1:0]        s_side;

   logic                 d_valid, d_ready;
   logic [1:0][W:0]      d_q;
   logic [1:0]           d_neg, d_ovf;
   logic [SW-1:0]        d_side;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= sit_pkg::TOL_RESET;
      end else if (csr_valid && csr_ready) begin
         tol_ff <= csr_data;
      end
   end

   sit_front #(.W(W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .p1_x      (req_p1_x),
      .p1_y      (req_p1_y),
      .p2_x      (req_p2_x),
      .p2_y      (req_p2_y),
      .q1_x      (req_q1_x),
      .q1_y      (req_q1_y),
      .q2_x      (req_q2_x),
      .q2_y      (req_q2_y),
      .tol       (tol_ff),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .den       (f_den),
      .cr        (f_cr),
      .nvq       (f_nvq),
      .nvp       (f_nvp),
      .p1x_o     (f_p1x),
      .p1y_o     (f_p1y),
      .q1x_o     (f_q1x),
      .dxp_o     (f_dxp),
      .dyp_o     (f_dyp),
      .dxq_o     (f_dxq),
      .case_o    (f_case),
      .bounds    (f_bounds)
   );

   sit_scale #(.W(W)) u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .den       (f_den),
      .cr        (f_cr),
      .nvq       (f_nvq),
      .nvp       (f_nvp),
      .p1x       (f_p1x),
      .p1y       (f_p1y),
      .q1x       (f_q1x),
      .dxp       (f_dxp),
      .dyp       (f_dyp),
      .dxq       (f_dxq),
      .case_i    (f_case),
      .bounds    (f_bounds),
      .out_valid (s_valid),
      .out_ready (s_ready),
      .nm        (s_nm),
      .dm        (s_dm),
      .neg       (s_neg),
      .side      (s_side)
   );

   sit_div #(.W(W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_valid),
      .in_ready  (s_ready),
      .nm        (s_nm),
      .dm        (s_dm),
      .neg       (s_neg),
      .side      (s_side),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .q         (d_q),
      .neg_o     (d_neg),
      .ovf       (d_ovf),
      .side_o    (d_side)
   );

   sit_back #(.W(W)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_ready  (d_ready),
      .q         (d_q),
      .neg       (d_neg),
      .ovf       (d_ovf),
      .side      (d_side),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .hit       (rsp_hit),
      .cross_x   (rsp_cross_x),
      .cross_y   (rsp_cross_y)
   );

   // a miss beat carries the origin
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_cross_x == '0 && rsp_cross_y == '0)
      else $error("miss beat with nonzero point");

   // intake only stalls when a finished beat is waiting at the output
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("intake stalled with output free");

   assert property (@(posedge clock)
      reset |=> tol_ff == sit_pkg::TOL_RESET)
      else $error("tolerance not restored by reset");

endmodule
